/* src/pdf_pkg.sv */
// Shared types, constants and coefficient tables of the polyphase decimating FIR.
package pdf_pkg;

  localparam int BRANCH_TAPS = 21;
  localparam int DECIMATION  = 2;
  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 32;
  localparam int SUM_W       = 32;
  localparam int TAP_IDX_W   = $clog2(BRANCH_TAPS);
  localparam int PROD_SHIFT  = 8;
  localparam int OUT_LSB     = 7;

  localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(BRANCH_TAPS - 1);
  localparam logic                 PHASE_ONE = 1'(DECIMATION - 1);

  typedef logic [TAP_IDX_W-1:0] tap_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } pdf_state_t;

  typedef struct packed {
    logic     shift;
    logic     phase;
    logic     mul_en;
    logic     acc_en;
    logic     emit;
    tap_idx_t idx;
  } pdf_cmd_t;

  function automatic logic signed [SAMPLE_W-1:0] coef_first(input tap_idx_t idx);
    logic signed [SAMPLE_W-1:0] c;
    case (idx)
      5'd0:    c = -16'sd353;
      5'd1:    c = 16'sd204;
      5'd2:    c = 16'sd20;
      5'd3:    c = -16'sd312;
      5'd4:    c = 16'sd639;
      5'd5:    c = -16'sd570;
      5'd6:    c = 16'sd15;
      5'd7:    c = 16'sd1149;
      5'd8:    c = -16'sd2501;
      5'd9:    c = 16'sd3669;
      5'd10:   c = 16'sd12302;
      5'd11:   c = 16'sd3669;
      5'd12:   c = -16'sd2501;
      5'd13:   c = 16'sd1149;
      5'd14:   c = 16'sd15;
      5'd15:   c = -16'sd570;
      5'd16:   c = 16'sd639;
      5'd17:   c = -16'sd312;
      5'd18:   c = 16'sd20;
      5'd19:   c = 16'sd204;
      5'd20:   c = -16'sd353;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] coef_second(input tap_idx_t idx);
    logic signed [SAMPLE_W-1:0] c;
    case (idx)
      5'd0:    c = -16'sd61;
      5'd1:    c = 16'sd299;
      5'd2:    c = -16'sd355;
      5'd3:    c = 16'sd224;
      5'd4:    c = 16'sd291;
      5'd5:    c = -16'sd874;
      5'd6:    c = 16'sd1248;
      5'd7:    c = -16'sd740;
      5'd8:    c = -16'sd1290;
      5'd9:    c = 16'sd9629;
      5'd10:   c = 16'sd9629;
      5'd11:   c = -16'sd1290;
      5'd12:   c = -16'sd740;
      5'd13:   c = 16'sd1248;
      5'd14:   c = -16'sd874;
      5'd15:   c = 16'sd291;
      5'd16:   c = 16'sd224;
      5'd17:   c = -16'sd355;
      5'd18:   c = 16'sd299;
      5'd19:   c = -16'sd61;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

/* src/polyphase_decimating_fir.sv */
// Top level of the polyphase decimate-by-two low-pass FIR.
//
// Samples arrive on the slave stream (s_tdata holds a signed Q1.15 sample, s_tlast
// an end marker) and filtered samples leave on the master stream at half the rate.
// Input samples alternate between two 21-tap branches; every second request
// produces one output whose tlast is the tlast of that second request.
// A request passes through the accept step, the tap sequence on the single shared
// multiplier (one tap per cycle), and a final step for the last add and output write.
// The next request is taken as soon as the controller returns to idle and not before,
// so the block takes no new request while it is busy with the last one; m_tvalid is
// set by the output write in the final step of the second request of a pair.
// The output register holds a finished result while the next pair is processed.
// If the receiver still holds off m_tready when the following result is ready,
// the block waits in its last step and takes no new request until it is free.
// Reset clears both delay lines, the phase and the running sum; no output is
// pending after reset.
module polyphase_decimating_fir
  import pdf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
  output logic                m_tlast
);

  pdf_cmd_t                   cmd;
  logic                       out_busy;
  logic signed [SAMPLE_W-1:0] sample_out;

  pdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  pdf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample_in  (s_tdata),
    .last_in    (s_tlast),
    .out_busy   (out_busy),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sample_out (sample_out),
    .last_out   (m_tlast)
  );

  assign m_tdata = sample_out;

endmodule

/* src/pdf_ctrl.sv */
// Controller state machine that sequences the shift, multiply-accumulate and output steps.
module pdf_ctrl
  import pdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_busy,
  output pdf_cmd_t cmd
);

  pdf_state_t state, state_next;
  tap_idx_t   idx, idx_next;
  logic       phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    phase_next = phase;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MAC;
          idx_next   = '0;
        end
      end
      ST_MAC: begin
        idx_next = idx + tap_idx_t'(1);
        if (idx == LAST_TAP) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (phase == PHASE_ONE) begin
          if (!out_busy) begin
            state_next = ST_IDLE;
            phase_next = 1'b0;
          end
        end else begin
          state_next = ST_IDLE;
          phase_next = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.shift  = 1'b0;
    cmd.phase  = phase;
    cmd.mul_en = 1'b0;
    cmd.acc_en = 1'b0;
    cmd.emit   = 1'b0;
    cmd.idx    = idx;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.shift = in_valid;
      end
      ST_MAC: begin
        cmd.mul_en = 1'b1;
        cmd.acc_en = (idx != '0);
      end
      ST_DRAIN: begin
        if (phase == PHASE_ONE) begin
          cmd.acc_en = !out_busy;
          cmd.emit   = !out_busy;
        end else begin
          cmd.acc_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (idx <= LAST_TAP))
    else $error("tap index out of range");

  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (phase == PHASE_ONE))
    else $error("output written on the wrong phase");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MAC && idx == '0))
    else $error("accepted request did not start the tap sequence");

endmodule

/* src/pdf_datapath.sv */
// Delay lines, shared multiplier, accumulator and output register of the decimating FIR.
module pdf_datapath
  import pdf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  pdf_cmd_t                   cmd,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       last_in,
  output logic                       out_busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       last_out
);

  logic signed [SAMPLE_W-1:0] branch_one_line [BRANCH_TAPS];
  logic signed [SAMPLE_W-1:0] branch_two_line [BRANCH_TAPS];
  logic signed [PROD_W-1:0]   prod;
  logic        [SUM_W-1:0]    running_sum;
  logic                       last_hold;
  logic signed [SAMPLE_W-1:0] tap_sample;
  logic signed [SAMPLE_W-1:0] tap_coef;
  logic        [SUM_W-1:0]    prod_ext;
  logic        [SUM_W-1:0]    sum_next;

  assign tap_sample = (cmd.phase == PHASE_ONE) ? branch_one_line[cmd.idx]
                                                : branch_two_line[cmd.idx];
  assign tap_coef   = (cmd.phase == PHASE_ONE) ? coef_first(cmd.idx) : coef_second(cmd.idx);
  assign prod_ext   = SUM_W'(prod >>> PROD_SHIFT);
  assign sum_next   = running_sum + prod_ext;
  assign out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BRANCH_TAPS; i++) begin
        branch_one_line[i] <= '0;
        branch_two_line[i] <= '0;
      end
    end else if (cmd.shift) begin
      if (cmd.phase == PHASE_ONE) begin
        for (int i = BRANCH_TAPS - 1; i > 0; i--) begin
          branch_one_line[i] <= branch_one_line[i-1];
        end
        branch_one_line[0] <= sample_in;
      end else begin
        for (int i = BRANCH_TAPS - 1; i > 0; i--) begin
          branch_two_line[i] <= branch_two_line[i-1];
        end
        branch_two_line[0] <= sample_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      last_hold <= last_in;
    end
    if (cmd.mul_en) begin
      prod <= tap_sample * tap_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (cmd.emit) begin
      running_sum <= '0;
    end else if (cmd.acc_en) begin
      running_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out <= sum_next[OUT_LSB +: SAMPLE_W];
      last_out   <= last_hold;
    end
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (running_sum == '0 && out_valid))
    else $error("sum not cleared or output not loaded after emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_busy)
    else $error("output register overwritten while held");

  a_no_shift_during_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |-> !cmd.shift)
    else $error("delay line shifted during the tap sequence");

endmodule

/* tb/polyphase_decimating_fir_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the polyphase decimate-by-two FIR with a scoreboard class.
module polyphase_decimating_fir_test;
  import pdf_pkg::*;

  localparam int ITEM_COUNT  = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 700;
  localparam int MAX_REPORTS = 10;

  localparam shortint FIRST_SET [BRANCH_TAPS] = '{
    -353, 204, 20, -312, 639, -570, 15, 1149, -2501, 3669, 12302,
    3669, -2501, 1149, 15, -570, 639, -312, 20, 204, -353
  };
  localparam shortint SECOND_SET [BRANCH_TAPS] = '{
    -61, 299, -355, 224, 291, -874, 1248, -740, -1290, 9629, 9629,
    -1290, -740, 1248, -874, 291, 224, -355, 299, -61, 0
  };

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } fir_output_t;

  class decimator_scoreboard;
    shortint     odd_line [BRANCH_TAPS];
    shortint     even_line [BRANCH_TAPS];
    bit          phase;
    int          running_sum;
    fir_output_t pending_outputs[$];
    int          errors;

    function new();
      foreach (odd_line[i]) begin
        odd_line[i] = 0;
        even_line[i] = 0;
      end
      phase = 0;
      running_sum = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] data, logic last);
      int          dot;
      int          prod;
      logic [31:0] bits;
      fir_output_t res;
      dot = 0;
      if (phase) begin
        for (int i = BRANCH_TAPS - 1; i > 0; i--) odd_line[i] = odd_line[i-1];
        odd_line[0] = shortint'(data);
        for (int i = 0; i < BRANCH_TAPS; i++) begin
          prod = int'(odd_line[i]) * int'(FIRST_SET[i]);
          dot += prod >>> PROD_SHIFT;
        end
      end else begin
        for (int i = BRANCH_TAPS - 1; i > 0; i--) even_line[i] = even_line[i-1];
        even_line[0] = shortint'(data);
        for (int i = 0; i < BRANCH_TAPS; i++) begin
          prod = int'(even_line[i]) * int'(SECOND_SET[i]);
          dot += prod >>> PROD_SHIFT;
        end
      end
      running_sum += dot;
      if (phase) begin
        bits = running_sum;
        res.sample = bits[OUT_LSB +: SAMPLE_W];
        res.last = last;
        pending_outputs.push_back(res);
        running_sum = 0;
      end
      phase = !phase;
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] data, logic last);
      fir_output_t want;
      if (pending_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected output: sample %0d last %0b", $signed(data), last);
        return;
      end
      want = pending_outputs.pop_front();
      if (want.sample !== data || want.last !== last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("output mismatch: sample expected %0d got %0d, last expected %0b got %0b",
                   $signed(want.sample), $signed(data), want.last, last);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [SAMPLE_W-1:0] m_tdata;
  logic                m_tlast;

  decimator_scoreboard sb;
  int                  items_sent = 0;
  int                  outputs_taken = 0;
  int                  cycles = 0;

  polyphase_decimating_fir dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        sb.check_output(m_tdata, m_tlast);
        outputs_taken++;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] data, input logic last);
    int gap;
    gap = ((items_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] driven_toward(input shortint coef, input bit invert);
    bit up;
    if (coef == 0) return SAMPLE_W'($urandom);
    up = (coef > 0) ^ invert;
    if (up) return SAMPLE_W'(32767 - $urandom_range(0, 255));
    return SAMPLE_W'(-32768 + $urandom_range(0, 255));
  endfunction

  // Fills both delay lines with samples whose signs follow the taps (or all oppose
  // them when invert is set), which drives the sum past the output range so it wraps.
  task automatic send_matched_burst(input bit invert);
    if (items_sent % 2) send_sample(SAMPLE_W'($urandom), 1'($urandom));
    for (int p = 0; p < BRANCH_TAPS; p++) begin
      send_sample(driven_toward(SECOND_SET[BRANCH_TAPS-1-p], invert), 1'b0);
      send_sample(driven_toward(FIRST_SET[BRANCH_TAPS-1-p], invert),
                  1'($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    int held;
    int gap;
    held = 0;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = ((outputs_taken / 60) % 4 == 2) ? 0 : $urandom_range(0, 5);
      if (!held && outputs_taken >= 150) begin
        held = 1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int kind;
    int run;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    repeat (2) send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h8000, 1'b1);
    repeat (2) send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h5555, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h7FFE, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0000, 1'b0);

    while (items_sent < ITEM_COUNT) begin
      kind = $urandom_range(0, 9);
      run = $urandom_range(2, 40);
      if (kind <= 4) begin
        repeat (run) send_sample(SAMPLE_W'($urandom), 1'($urandom));
      end else if (kind <= 6) begin
        repeat (run)
          send_sample(SAMPLE_W'($urandom_range(0, 127) - 64), 1'($urandom_range(0, 7) == 0));
      end else if (kind == 7) begin
        repeat (run)
          send_sample($urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 1'($urandom));
      end else begin
        send_matched_burst(1'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
